// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// No dependencies; imported by deq_cell, deq_chain and double_ended_queue_top.
package deq_pkg;

  localparam int DataW        = 32;
  localparam int FillW        = 7;
  localparam int DepthDefault = 64;

  // operation codes carried by mode_i
  localparam logic [1:0] ModePushFront = 2'd0;
  localparam logic [1:0] ModePushBack  = 2'd1;
  localparam logic [1:0] ModePopFront  = 2'd2;
  localparam logic [1:0] ModePopBack   = 2'd3;

  // status codes carried by status_o
  localparam logic [1:0] StDone      = 2'd0;
  localparam logic [1:0] StUnderflow = 2'd1;
  localparam logic [1:0] StOverflow  = 2'd2;

  // command broadcast to one row of cells
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH_TOP,   // shift toward the tail, new value enters cell 0
    CMD_POP_TOP,    // shift toward cell 0
    CMD_INS_AT      // write the value into the cell at index count
  } chain_cmd_e;

  // per-cell source select
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD
  } cell_sel_e;

endpackage

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of a row: holds a word, takes it from a neighbor or the input.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
  input  logic             clk_i,
  input  cell_sel_e        sel_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  input  logic [DataW-1:0] load_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    case (sel_i)
      SEL_LEFT:  data_d = left_i;
      SEL_RIGHT: data_d = right_i;
      SEL_LOAD:  data_d = load_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/deq_chain.sv =====
// Row of DEPTH cells with its top at cell 0; decodes the broadcast command per cell.
// Depends on deq_pkg and deq_cell.
module deq_chain import deq_pkg::*; #(
  parameter int Depth  = DepthDefault,
  parameter int CountW = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  chain_cmd_e        cmd_i,
  input  logic [DataW-1:0]  value_i,
  input  logic [CountW-1:0] count_i,
  output logic [DataW-1:0]  top_o
);

  logic [DataW-1:0] data [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam logic [CountW-1:0] Idx = CountW'(i);
    cell_sel_e        sel;
    logic [DataW-1:0] left, right;

    always_comb begin
      case (cmd_i)
        CMD_PUSH_TOP: sel = SEL_LEFT;
        CMD_POP_TOP:  sel = SEL_RIGHT;
        CMD_INS_AT:   sel = (count_i == Idx) ? SEL_LOAD : SEL_HOLD;
        default:      sel = SEL_HOLD;
      endcase
    end

    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_inner_l
      assign left = data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = data[i+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel),
      .left_i  (left),
      .right_i (right),
      .load_i  (value_i),
      .data_o  (data[i])
    );
  end

  assign top_o = data[0];

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg and deq_chain (which uses deq_cell).
//
//  channel | handshake              | beat fields
//  --------+------------------------+------------------------------------------------
//  input   | start & !busy          | mode_i, push_value_i
//  result  | valid_o (one cycle)    | popped_value_o, status_o, front_value_o,
//          |                        | back_value_o, is_empty_o, fill_count_o
//
// Cycles: one operation per clock. The result beat appears on the cycle after
//   the operation is accepted and lasts exactly that one cycle.
// Reset: rst_ni clears the fill count and the result strobe; the cell rows are
//   not cleared, entries above the fill count are never shown.
// Stalls: busy stays low, the block never holds off start; the receiver cannot
//   stall, each result is taken in its one valid cycle.
//
// Storage is two rows of DEPTH cells holding the same entries in opposite
// order: row A has the front entry in cell 0, row B has the back entry in
// cell 0. A push at a row's own end shifts that row one cell down the line;
// the other row writes the word at index count. A pop at a row's own end
// shifts it back toward cell 0; the other row just loses the entry through
// the count. So front and back are always read from a fixed cell.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] front_value_o,
  output logic signed [DataW-1:0] back_value_o,
  output logic                    is_empty_o,
  output logic [FillW-1:0]        fill_count_o
);

  localparam int CountW = $clog2(DEPTH + 1);
  localparam logic [CountW-1:0] CountFull = CountW'(DEPTH);

  logic [CountW-1:0] count_q, count_d;
  logic              valid_q;
  logic [DataW-1:0]  popped_q, popped_d;
  logic [1:0]        status_q, status_d;

  logic              accept, full, empty;
  chain_cmd_e        cmd_a, cmd_b;
  logic [DataW-1:0]  top_a, top_b;
  logic [CountW+FillW-1:0] count_ext;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = (count_q == CountFull);
  assign empty  = (count_q == '0);

  always_comb begin
    cmd_a    = CMD_NONE;
    cmd_b    = CMD_NONE;
    count_d  = count_q;
    popped_d = '0;
    status_d = StDone;
    if (accept) begin
      case (mode_i)
        ModePushFront: begin
          if (full) begin
            status_d = StOverflow;
          end else begin
            cmd_a   = CMD_PUSH_TOP;
            cmd_b   = CMD_INS_AT;
            count_d = count_q + CountW'(1);
          end
        end
        ModePushBack: begin
          if (full) begin
            status_d = StOverflow;
          end else begin
            cmd_a   = CMD_INS_AT;
            cmd_b   = CMD_PUSH_TOP;
            count_d = count_q + CountW'(1);
          end
        end
        ModePopFront: begin
          if (empty) begin
            status_d = StUnderflow;
          end else begin
            cmd_a    = CMD_POP_TOP;
            popped_d = top_a;
            count_d  = count_q - CountW'(1);
          end
        end
        default: begin  // pop back
          if (empty) begin
            status_d = StUnderflow;
          end else begin
            cmd_b    = CMD_POP_TOP;
            popped_d = top_b;
            count_d  = count_q - CountW'(1);
          end
        end
      endcase
    end
  end

  // front-first row
  deq_chain #(
    .Depth  (DEPTH),
    .CountW (CountW)
  ) u_row_a (
    .clk_i   (clk_i),
    .cmd_i   (cmd_a),
    .value_i (push_value_i),
    .count_i (count_q),
    .top_o   (top_a)
  );

  // back-first row
  deq_chain #(
    .Depth  (DEPTH),
    .CountW (CountW)
  ) u_row_b (
    .clk_i   (clk_i),
    .cmd_i   (cmd_b),
    .value_i (push_value_i),
    .count_i (count_q),
    .top_o   (top_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  // state after the operation is in the registers during the result cycle
  assign count_ext      = {{FillW{1'b0}}, count_q};
  assign valid_o        = valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = empty ? '0 : top_a;
  assign back_value_o   = empty ? '0 : top_b;
  assign is_empty_o     = empty;
  assign fill_count_o   = count_ext[FillW-1:0];

`ifndef NO_ASSERTIONS
  a_strobe_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> valid_o)
    else $error("result strobe missing after accepted operation");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("fill count beyond depth");

  a_single_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && count_q == CountW'(1) |-> front_value_o == back_value_o)
    else $error("rows disagree on the only entry");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StOverflow |-> count_q == CountFull && $stable(count_q))
    else $error("overflow reported while not full");

  a_underflow_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StUnderflow |-> popped_value_o == '0 && is_empty_o)
    else $error("underflow with data or entries present");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for double_ended_queue_top: directed and random operations checked
// against a cycle-free predictor of the ring-buffer deque.
// Depends on deq_pkg and the double_ended_queue_top RTL.
module testbench;
  import deq_pkg::*;

  localparam int QDepth = DepthDefault;
  localparam int IdxW   = $clog2(QDepth);

  // one expected result beat
  typedef struct {
    logic signed [DataW-1:0] popped;
    logic [1:0]              status;
    logic signed [DataW-1:0] front;
    logic signed [DataW-1:0] back;
    logic                    empty;
    logic [FillW-1:0]        fill;
  } deq_beat_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              mode_i;
  logic signed [DataW-1:0] push_value_i;
  logic                    valid_o;
  logic signed [DataW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] front_value_o;
  logic signed [DataW-1:0] back_value_o;
  logic                    is_empty_o;
  logic [FillW-1:0]        fill_count_o;

  double_ended_queue_top #(
    .DEPTH(QDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .push_value_i  (push_value_i),
    .valid_o       (valid_o),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .fill_count_o  (fill_count_o)
  );

  // Shadow deque in ring-buffer form, head marks the front entry.
  logic signed [DataW-1:0] shadow_ring [QDepth];
  logic [IdxW-1:0]         shadow_head;
  int unsigned             shadow_count;

  deq_beat_t pending_beats[$];   // expected beats, oldest first
  deq_beat_t oldest_beat;

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned ops_accepted;
  int unsigned overflow_seen;
  int unsigned underflow_seen;
  int unsigned full_hits;
  int unsigned wrap_pushes;      // front pushes that moved head through zero

  // ---------------------------------------------------------------------------
  // Clock and limit
  // ---------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ~700 ops with their idle gaps end well before this limit;
  // this gives a wide margin.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one operation to the shadow deque and returns the beat
  // the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic deq_beat_t apply_deq_op(logic [1:0] op, logic signed [DataW-1:0] val);
    deq_beat_t       r;
    logic [IdxW-1:0] tail_idx;
    r.popped = '0;
    r.status = StDone;
    r.front  = '0;
    r.back   = '0;
    case (op)
      ModePushFront, ModePushBack: begin
        if (shadow_count >= QDepth) begin
          r.status = StOverflow;
          overflow_seen++;
        end else if (op == ModePushFront) begin
          if (shadow_head == '0) wrap_pushes++;
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = val;
          shadow_count++;
        end else begin
          tail_idx = shadow_head + IdxW'(shadow_count);
          shadow_ring[tail_idx] = val;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = StUnderflow;
          underflow_seen++;
        end else if (op == ModePopFront) begin
          r.popped = shadow_ring[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_count--;
        end else begin
          tail_idx = shadow_head + IdxW'(shadow_count - 1);
          r.popped = shadow_ring[tail_idx];
          shadow_count--;
        end
      end
    endcase
    if (shadow_count != 0) begin
      tail_idx = shadow_head + IdxW'(shadow_count - 1);
      r.front  = shadow_ring[shadow_head];
      r.back   = shadow_ring[tail_idx];
    end
    if (shadow_count == QDepth) full_hits++;
    r.empty = (shadow_count == 0);
    r.fill  = FillW'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's
  // own updates land, so a beat seen here is the one held over the past cycle.
  // The check of the past beat runs before the prediction of the op accepted
  // at this same edge; order is kept by sitting in one process.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_beats.size() == 0) begin
          $error("result beat with no operation outstanding");
          mismatches++;
        end else begin
          oldest_beat = pending_beats[0];
          pending_beats.delete(0);
          beats_checked++;
          check_field("popped_value", oldest_beat.popped, popped_value_o);
          check_field("status", DataW'(oldest_beat.status), DataW'(status_o));
          check_field("front_value", oldest_beat.front, front_value_o);
          check_field("back_value", oldest_beat.back, back_value_o);
          check_field("is_empty", DataW'(oldest_beat.empty), DataW'(is_empty_o));
          check_field("fill_count", DataW'(oldest_beat.fill), DataW'(fill_count_o));
        end
      end
      if (start && !busy) begin
        pending_beats.insert(pending_beats.size(), apply_deq_op(mode_i, push_value_i));
        ops_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Drives one op and holds it until an edge with busy low takes it.
  task automatic send_op(logic [1:0] op, logic signed [DataW-1:0] val);
    start        <= 1'b1;
    mode_i       <= op;
    push_value_i <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Idles with start low and random junk on the payload ports.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      start        <= 1'b0;
      mode_i       <= 2'($urandom);
      push_value_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding beat has been checked.
  task automatic wait_drained();
    idle_cycles(1);
    while (pending_beats.size() != 0) idle_cycles(1);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      4:       return DataW'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops on an empty deque right out of reset: underflow, state untouched.
  task automatic test_empty_pops();
    send_op(ModePopFront, 32'sh7fff_ffff);
    send_op(ModePopBack, 32'sh8000_0000);
    send_op(ModePopFront, -32'sd1);
    wait_drained();
  endtask

  // Extreme words through both ends; front push at head 0 wraps the ring.
  task automatic test_extreme_values();
    send_op(ModePushFront, 32'sh7fff_ffff);
    send_op(ModePushBack, 32'sh8000_0000);
    send_op(ModePushFront, '0);
    send_op(ModePushBack, -32'sd1);
    send_op(ModePopFront, 32'sh5555_5555);
    send_op(ModePopBack, 32'shaaaa_aaaa);
    send_op(ModePopBack, '0);
    send_op(ModePopFront, '0);
    send_op(ModePopFront, '0);
    send_op(ModePopBack, '0);
    wait_drained();
  endtask

  // One entry seen from both ends, then push/pop at opposite ends.
  task automatic test_cross_ends();
    send_op(ModePushBack, 32'sd1);
    send_op(ModePopFront, '0);
    send_op(ModePushFront, 32'sd2);
    send_op(ModePopBack, '0);
    send_op(ModePushBack, 32'sd3);
    send_op(ModePushBack, 32'sd4);
    send_op(ModePushFront, 32'sd5);
    send_op(ModePopBack, '0);
    send_op(ModePopFront, '0);
    send_op(ModePopFront, '0);
    wait_drained();
  endtask

  // Random ops in regimes that lean toward pushes, pops or neither, so the
  // deque runs full and empty many times with the head wrapping around.
  // Bursts and gaps are drawn apart from the regimes so idle cycles land on
  // every fill level; some regimes run without any gap.
  task automatic test_random_ops(int unsigned total);
    int unsigned sent;
    int unsigned regime_left;
    int unsigned push_pct;
    int unsigned burst_left;
    bit          no_gaps;
    logic [1:0]  op;
    sent        = 0;
    regime_left = 120;
    push_pct    = 90;       // first regime fills the deque for sure
    burst_left  = 0;
    no_gaps     = 1'b0;
    while (sent < total) begin
      if (regime_left == 0) begin
        regime_left = $urandom_range(60, 150);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if (!no_gaps) idle_cycles($urandom_range(0, 6));
      end
      if ($urandom_range(1, 100) <= push_pct) begin
        op = ($urandom_range(0, 1) != 0) ? ModePushFront : ModePushBack;
      end else begin
        op = ($urandom_range(0, 1) != 0) ? ModePopFront : ModePopBack;
      end
      send_op(op, pick_value());
      sent++;
      regime_left--;
      burst_left--;
      // hold off now and then until the block has answered everything
      if (sent % 200 == 0) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches     = 0;
    beats_checked  = 0;
    ops_accepted   = 0;
    overflow_seen  = 0;
    underflow_seen = 0;
    full_hits      = 0;
    wrap_pushes    = 0;
    shadow_head    = '0;
    shadow_count   = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = ModePushFront;
    push_value_i   = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pops();
    test_extreme_values();
    test_cross_ends();
    test_random_ops(650);

    // let any stray beat show up before the final tally
    idle_cycles(5);
    if (pending_beats.size() != 0) begin
      $error("%0d expected beats never arrived", pending_beats.size());
      mismatches += pending_beats.size();
    end

    $display("Ran %0d ops, %0d beats checked: %0d overflows, %0d underflows,",
             ops_accepted, beats_checked, overflow_seen, underflow_seen);
    $display("deque full after %0d ops, head wrapped by front push %0d times",
             full_hits, wrap_pushes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_top.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_chain.sv
hw/rtl/double_ended_queue_top.sv
sim/testbench.sv
